// ----- sv/pcrf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pcrf_pkg;

  // Input byte width, Q1.15 result width, and divisor width
  localparam int unsigned NUM_W     = 8;
  localparam int unsigned QUO_W     = 16;
  localparam int unsigned DEN_W     = 16;
  localparam int unsigned FRAC_BITS = 15;

  localparam logic [QUO_W-1:0] Q_ONE     = 16'd32768;
  localparam logic [DEN_W-1:0] HUE_SPAN  = 16'd180;
  localparam logic [DEN_W-1:0] BYTE_SPAN = 16'd255;

  // Ratio lanes that need a true divide
  localparam int unsigned DIV_LANES = 6;

  // Bytes that ride along the divider for the constant-divisor features
  typedef struct packed {
    logic [NUM_W-1:0] sat_hsv;
    logic [NUM_W-1:0] val_hsv;
    logic [NUM_W-1:0] light_hls;
    logic [NUM_W-1:0] sat_hls;
    logic [NUM_W-1:0] blue;
    logic [NUM_W:0]   green_red;
  } side_t;

  localparam int unsigned SIDE_W = $bits(side_t);

endpackage

`default_nettype wire

// ----- sv/pixel_color_ratio_features_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pixel color ratio features.
// Input channel (in_valid/in_ready) takes one pixel word: HSV, HLS and BGR
// bytes. Output channel (out_valid/out_ready) returns one word of twelve Q1.15
// features (32768 = 1.0), each truncated and clamped to 1.0.
// Pipeline: one capture stage, sixteen restoring-divider stages (one quotient
// bit each), one output register with the clamp and the constant-divisor
// features.
// Throughput: one pixel per cycle while out_ready stays high; a new pixel is
// accepted while the previous result sits in the output register.
// Stall: when the output register is full and out_ready is low, the whole
// pipeline holds and in_ready drops in the same cycle; nothing is lost or
// repeated. in_ready depends combinationally on out_ready.
// Reset: rst_n (synchronous, active low) clears all stage valid bits and
// out_valid; the data registers are not reset.
module pixel_color_ratio_features_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [pcrf_pkg::NUM_W-1:0]      in_hue_hsv,
  input  wire logic [pcrf_pkg::NUM_W-1:0]      in_sat_hsv,
  input  wire logic [pcrf_pkg::NUM_W-1:0]      in_val_hsv,
  input  wire logic [pcrf_pkg::NUM_W-1:0]      in_hue_hls,
  input  wire logic [pcrf_pkg::NUM_W-1:0]      in_light_hls,
  input  wire logic [pcrf_pkg::NUM_W-1:0]      in_sat_hls,
  input  wire logic [pcrf_pkg::NUM_W-1:0]      in_blue,
  input  wire logic [pcrf_pkg::NUM_W-1:0]      in_green,
  input  wire logic [pcrf_pkg::NUM_W-1:0]      in_red,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [pcrf_pkg::QUO_W-1:0]      out_sat_hsv_norm,
  output logic      [pcrf_pkg::QUO_W-1:0]      out_val_hsv_norm,
  output logic      [pcrf_pkg::QUO_W-1:0]      out_hue_per_sat_hsv,
  output logic      [pcrf_pkg::QUO_W-1:0]      out_hue_per_val_hsv,
  output logic      [pcrf_pkg::QUO_W-1:0]      out_sat_per_val_hsv,
  output logic      [pcrf_pkg::QUO_W-1:0]      out_light_hls_norm,
  output logic      [pcrf_pkg::QUO_W-1:0]      out_sat_hls_norm,
  output logic      [pcrf_pkg::QUO_W-1:0]      out_hue_per_light_hls,
  output logic      [pcrf_pkg::QUO_W-1:0]      out_hue_per_sat_hls,
  output logic      [pcrf_pkg::QUO_W-1:0]      out_light_per_sat_hls,
  output logic      [pcrf_pkg::QUO_W-1:0]      out_blue_norm,
  output logic      [pcrf_pkg::QUO_W-1:0]      out_green_red_norm
);

  import pcrf_pkg::*;

  // Divider lane assignment
  localparam int unsigned LN_HUE_SAT_HSV   = 0;
  localparam int unsigned LN_HUE_VAL_HSV   = 1;
  localparam int unsigned LN_SAT_VAL_HSV   = 2;
  localparam int unsigned LN_HUE_LIGHT_HLS = 3;
  localparam int unsigned LN_HUE_SAT_HLS   = 4;
  localparam int unsigned LN_LIGHT_SAT_HLS = 5;

  // span * (b + 1), at most 255 * 256
  function automatic logic [DEN_W-1:0] den_of(input logic [NUM_W-1:0] b,
                                               input logic [DEN_W-1:0] span);
    logic [NUM_W:0] p1;
    p1 = {1'b0, b} + {{NUM_W{1'b0}}, 1'b1};
    return DEN_W'({{(DEN_W-NUM_W-1){1'b0}}, p1} * span);
  endfunction

  // floor(m * 256 / 255) for m up to 128 * 255: m + floor(m / 255)
  function automatic logic [QUO_W-1:0] scale255(input logic [14:0] m);
    logic [15:0] t;
    t = {1'b0, m} + {9'b0, m[14:8]} + 16'd1;
    return {1'b0, m} + {8'b0, t[15:8]};
  endfunction

  function automatic logic [QUO_W-1:0] clamp_one(input logic [QUO_W-1:0] q);
    return (q > Q_ONE) ? Q_ONE : q;
  endfunction

  logic                                en;
  logic [DIV_LANES-1:0][NUM_W-1:0]     div_num;
  logic [DIV_LANES-1:0][DEN_W-1:0]     div_den;
  side_t                               side_in;
  logic [SIDE_W-1:0]                   div_side;
  side_t                               side_out;
  logic                                div_valid;
  logic [DIV_LANES-1:0][QUO_W-1:0]     div_quo;

  logic                                out_valid_r, out_valid_nxt;
  logic [11:0][QUO_W-1:0]              feat_r, feat_nxt;

  // Advance everything unless a finished word is waiting on the receiver
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    div_num[LN_HUE_SAT_HSV]   = in_hue_hsv;
    div_den[LN_HUE_SAT_HSV]   = den_of(in_sat_hsv, HUE_SPAN);
    div_num[LN_HUE_VAL_HSV]   = in_hue_hsv;
    div_den[LN_HUE_VAL_HSV]   = den_of(in_val_hsv, HUE_SPAN);
    div_num[LN_SAT_VAL_HSV]   = in_sat_hsv;
    div_den[LN_SAT_VAL_HSV]   = den_of(in_val_hsv, BYTE_SPAN);
    div_num[LN_HUE_LIGHT_HLS] = in_hue_hls;
    div_den[LN_HUE_LIGHT_HLS] = den_of(in_light_hls, HUE_SPAN);
    div_num[LN_HUE_SAT_HLS]   = in_hue_hls;
    div_den[LN_HUE_SAT_HLS]   = den_of(in_sat_hls, HUE_SPAN);
    div_num[LN_LIGHT_SAT_HLS] = in_light_hls;
    div_den[LN_LIGHT_SAT_HLS] = den_of(in_sat_hls, BYTE_SPAN);

    side_in.sat_hsv   = in_sat_hsv;
    side_in.val_hsv   = in_val_hsv;
    side_in.light_hls = in_light_hls;
    side_in.sat_hls   = in_sat_hls;
    side_in.blue      = in_blue;
    side_in.green_red = {1'b0, in_green} + {1'b0, in_red};
  end

  pcrf_div_pipe #(
    .LANES  (DIV_LANES),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_num    (div_num),
    .in_den    (div_den),
    .in_side   (side_in),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  assign side_out = side_t'(div_side);

  always_comb begin
    out_valid_nxt = div_valid;
    feat_nxt[0]   = scale255({side_out.sat_hsv, 7'b0});
    feat_nxt[1]   = scale255({side_out.val_hsv, 7'b0});
    feat_nxt[2]   = clamp_one(div_quo[LN_HUE_SAT_HSV]);
    feat_nxt[3]   = clamp_one(div_quo[LN_HUE_VAL_HSV]);
    feat_nxt[4]   = clamp_one(div_quo[LN_SAT_VAL_HSV]);
    feat_nxt[5]   = scale255({side_out.light_hls, 7'b0});
    feat_nxt[6]   = scale255({side_out.sat_hls, 7'b0});
    feat_nxt[7]   = clamp_one(div_quo[LN_HUE_LIGHT_HLS]);
    feat_nxt[8]   = clamp_one(div_quo[LN_HUE_SAT_HLS]);
    feat_nxt[9]   = clamp_one(div_quo[LN_LIGHT_SAT_HLS]);
    feat_nxt[10]  = scale255({side_out.blue, 7'b0});
    // (G+R)/510 is (G+R)*64 scaled by 256/255
    feat_nxt[11]  = scale255({side_out.green_red, 6'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      feat_r <= feat_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_sat_hsv_norm      = feat_r[0];
  assign out_val_hsv_norm      = feat_r[1];
  assign out_hue_per_sat_hsv   = feat_r[2];
  assign out_hue_per_val_hsv   = feat_r[3];
  assign out_sat_per_val_hsv   = feat_r[4];
  assign out_light_hls_norm    = feat_r[5];
  assign out_sat_hls_norm      = feat_r[6];
  assign out_hue_per_light_hls = feat_r[7];
  assign out_hue_per_sat_hls   = feat_r[8];
  assign out_light_per_sat_hls = feat_r[9];
  assign out_blue_norm         = feat_r[10];
  assign out_green_red_norm    = feat_r[11];

endmodule

`default_nettype wire

// ----- sv/pcrf_div_pipe.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage, all lanes side by side.
// Each lane computes floor(num * 2^FRAC_BITS / den); the caller guarantees the
// quotient fits in QUO_W bits.
module pcrf_div_pipe #(
  parameter int unsigned LANES  = pcrf_pkg::DIV_LANES,
  parameter int unsigned SIDE_W = pcrf_pkg::SIDE_W
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     en,
  input  wire logic                                     in_valid,
  input  wire logic [LANES-1:0][pcrf_pkg::NUM_W-1:0]    in_num,
  input  wire logic [LANES-1:0][pcrf_pkg::DEN_W-1:0]    in_den,
  input  wire logic [SIDE_W-1:0]                        in_side,
  output logic                                          out_valid,
  output logic      [LANES-1:0][pcrf_pkg::QUO_W-1:0]    out_quo,
  output logic      [SIDE_W-1:0]                        out_side
);

  import pcrf_pkg::*;

  localparam int unsigned NSTEP  = QUO_W;
  localparam int unsigned NUMX_W = NUM_W + FRAC_BITS;

  logic [NSTEP:0]                         vld_r, vld_nxt;
  logic [NSTEP:0][LANES-1:0][DEN_W-1:0]   rem_r, rem_nxt;
  logic [NSTEP:0][LANES-1:0][QUO_W-1:0]   quo_r, quo_nxt;
  logic [NSTEP:0][LANES-1:0][DEN_W-1:0]   den_r, den_nxt;
  logic [NSTEP:0][SIDE_W-1:0]             side_r, side_nxt;

  always_comb begin
    logic [NUMX_W-1:0] numx;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    vld_nxt     = {vld_r[NSTEP-1:0], in_valid};
    side_nxt[0] = in_side;
    for (int l = 0; l < LANES; l++) begin
      // Scaled numerator: top bits seed the remainder, low bits shift in later
      numx          = {in_num[l], {FRAC_BITS{1'b0}}};
      rem_nxt[0][l] = DEN_W'(numx >> QUO_W);
      quo_nxt[0][l] = numx[QUO_W-1:0];
      den_nxt[0][l] = in_den[l];
    end
    for (int k = 1; k <= NSTEP; k++) begin
      side_nxt[k] = side_r[k-1];
      for (int l = 0; l < LANES; l++) begin
        trial         = {rem_r[k-1][l], quo_r[k-1][l][QUO_W-1]};
        diff          = trial - {1'b0, den_r[k-1][l]};
        ge            = (trial >= {1'b0, den_r[k-1][l]});
        rem_nxt[k][l] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        // numerator bits leave at the top, quotient bits enter at the bottom
        quo_nxt[k][l] = {quo_r[k-1][l][QUO_W-2:0], ge};
        den_nxt[k][l] = den_r[k-1][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      den_r  <= den_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = vld_r[NSTEP];
  assign out_side  = side_r[NSTEP];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_quo[l] = quo_r[NSTEP][l];
    end
  end

endmodule

`default_nettype wire

// ----- sv/pcrf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pcrf_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_ready,
  input  wire logic [pcrf_pkg::NUM_W-1:0]   in_hue_hsv,
  input  wire logic [pcrf_pkg::NUM_W-1:0]   in_sat_hsv,
  input  wire logic [pcrf_pkg::NUM_W-1:0]   in_val_hsv,
  input  wire logic [pcrf_pkg::NUM_W-1:0]   in_hue_hls,
  input  wire logic [pcrf_pkg::NUM_W-1:0]   in_light_hls,
  input  wire logic [pcrf_pkg::NUM_W-1:0]   in_sat_hls,
  input  wire logic [pcrf_pkg::NUM_W-1:0]   in_blue,
  input  wire logic [pcrf_pkg::NUM_W-1:0]   in_green,
  input  wire logic [pcrf_pkg::NUM_W-1:0]   in_red,
  input  wire logic                         out_valid,
  input  wire logic                         out_ready,
  input  wire logic [pcrf_pkg::QUO_W-1:0]   out_sat_hsv_norm,
  input  wire logic [pcrf_pkg::QUO_W-1:0]   out_val_hsv_norm,
  input  wire logic [pcrf_pkg::QUO_W-1:0]   out_hue_per_sat_hsv,
  input  wire logic [pcrf_pkg::QUO_W-1:0]   out_hue_per_val_hsv,
  input  wire logic [pcrf_pkg::QUO_W-1:0]   out_sat_per_val_hsv,
  input  wire logic [pcrf_pkg::QUO_W-1:0]   out_light_hls_norm,
  input  wire logic [pcrf_pkg::QUO_W-1:0]   out_sat_hls_norm,
  input  wire logic [pcrf_pkg::QUO_W-1:0]   out_hue_per_light_hls,
  input  wire logic [pcrf_pkg::QUO_W-1:0]   out_hue_per_sat_hls,
  input  wire logic [pcrf_pkg::QUO_W-1:0]   out_light_per_sat_hls,
  input  wire logic [pcrf_pkg::QUO_W-1:0]   out_blue_norm,
  input  wire logic [pcrf_pkg::QUO_W-1:0]   out_green_red_norm
);

  import pcrf_pkg::*;

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hue_per_sat_hsv)
      && $stable(out_sat_per_val_hsv) && $stable(out_light_per_sat_hls)
      && $stable(out_green_red_norm))
    else $error("stalled output word changed");

  // Pipeline backs up exactly when the output word is stuck
  a_ready_map: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output occupancy");

  // Every divided feature, blue_norm and green_red_norm stay clamped to 1.0
  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue_per_sat_hsv <= Q_ONE && out_hue_per_val_hsv <= Q_ONE
      && out_sat_per_val_hsv <= Q_ONE && out_hue_per_light_hls <= Q_ONE
      && out_hue_per_sat_hls <= Q_ONE && out_light_per_sat_hls <= Q_ONE
      && out_green_red_norm <= Q_ONE && out_blue_norm <= Q_ONE)
    else $error("feature above 1.0");

endmodule

bind pixel_color_ratio_features_core pcrf_checker u_pcrf_checker (.*);

`default_nettype wire

// ----- tb/pcrf_feature_checker.sv -----
`timescale 1ns / 1ps

module pcrf_feature_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [pcrf_pkg::NUM_W-1:0]   in_hue_hsv,
  input  logic [pcrf_pkg::NUM_W-1:0]   in_sat_hsv,
  input  logic [pcrf_pkg::NUM_W-1:0]   in_val_hsv,
  input  logic [pcrf_pkg::NUM_W-1:0]   in_hue_hls,
  input  logic [pcrf_pkg::NUM_W-1:0]   in_light_hls,
  input  logic [pcrf_pkg::NUM_W-1:0]   in_sat_hls,
  input  logic [pcrf_pkg::NUM_W-1:0]   in_blue,
  input  logic [pcrf_pkg::NUM_W-1:0]   in_green,
  input  logic [pcrf_pkg::NUM_W-1:0]   in_red,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [pcrf_pkg::QUO_W-1:0]   out_sat_hsv_norm,
  input  logic [pcrf_pkg::QUO_W-1:0]   out_val_hsv_norm,
  input  logic [pcrf_pkg::QUO_W-1:0]   out_hue_per_sat_hsv,
  input  logic [pcrf_pkg::QUO_W-1:0]   out_hue_per_val_hsv,
  input  logic [pcrf_pkg::QUO_W-1:0]   out_sat_per_val_hsv,
  input  logic [pcrf_pkg::QUO_W-1:0]   out_light_hls_norm,
  input  logic [pcrf_pkg::QUO_W-1:0]   out_sat_hls_norm,
  input  logic [pcrf_pkg::QUO_W-1:0]   out_hue_per_light_hls,
  input  logic [pcrf_pkg::QUO_W-1:0]   out_hue_per_sat_hls,
  input  logic [pcrf_pkg::QUO_W-1:0]   out_light_per_sat_hls,
  input  logic [pcrf_pkg::QUO_W-1:0]   out_blue_norm,
  input  logic [pcrf_pkg::QUO_W-1:0]   out_green_red_norm,
  output int unsigned                  fail_count,
  output int unsigned                  pending,
  output int unsigned                  words_checked,
  output int unsigned                  clamp_count
);

  import pcrf_pkg::*;

  localparam int unsigned FULL_SCALE = 32768;
  localparam int unsigned HUE_DEN    = 180;
  localparam int unsigned BYTE_DEN   = 255;
  localparam int unsigned N_FEAT     = 12;

  typedef enum int unsigned {
    F_SAT_HSV_NORM, F_VAL_HSV_NORM, F_HUE_PER_SAT_HSV, F_HUE_PER_VAL_HSV,
    F_SAT_PER_VAL_HSV, F_LIGHT_HLS_NORM, F_SAT_HLS_NORM, F_HUE_PER_LIGHT_HLS,
    F_HUE_PER_SAT_HLS, F_LIGHT_PER_SAT_HLS, F_BLUE_NORM, F_GREEN_RED_NORM
  } feature_idx_t;

  typedef logic [N_FEAT-1:0][QUO_W-1:0] feature_set_t;

  string feature_name [N_FEAT] = '{
    "sat_hsv_norm", "val_hsv_norm", "hue_per_sat_hsv", "hue_per_val_hsv",
    "sat_per_val_hsv", "light_hls_norm", "sat_hls_norm", "hue_per_light_hls",
    "hue_per_sat_hls", "light_per_sat_hls", "blue_norm", "green_red_norm"
  };

  feature_set_t expected_features [$];
  int unsigned  fails   = 0;
  int unsigned  checked = 0;
  int unsigned  clamped = 0;

  // Truncated Q1.15 quotient, saturated at 1.0
  function automatic logic [QUO_W-1:0] q15_ratio(input int unsigned num,
                                                input int unsigned den);
    int unsigned quo;
    quo = (num << FRAC_BITS) / den;
    return (quo > FULL_SCALE) ? QUO_W'(FULL_SCALE) : QUO_W'(quo);
  endfunction

  function automatic feature_set_t pixel_features(
    input logic [NUM_W-1:0] h1, s1, v1, h2, l2, s2, b, g, r);
    feature_set_t f;
    f[F_SAT_HSV_NORM]      = q15_ratio(32'(s1), BYTE_DEN);
    f[F_VAL_HSV_NORM]      = q15_ratio(32'(v1), BYTE_DEN);
    f[F_HUE_PER_SAT_HSV]   = q15_ratio(32'(h1), HUE_DEN * (32'(s1) + 1));
    f[F_HUE_PER_VAL_HSV]   = q15_ratio(32'(h1), HUE_DEN * (32'(v1) + 1));
    f[F_SAT_PER_VAL_HSV]   = q15_ratio(32'(s1), BYTE_DEN * (32'(v1) + 1));
    f[F_LIGHT_HLS_NORM]    = q15_ratio(32'(l2), BYTE_DEN);
    f[F_SAT_HLS_NORM]      = q15_ratio(32'(s2), BYTE_DEN);
    f[F_HUE_PER_LIGHT_HLS] = q15_ratio(32'(h2), HUE_DEN * (32'(l2) + 1));
    f[F_HUE_PER_SAT_HLS]   = q15_ratio(32'(h2), HUE_DEN * (32'(s2) + 1));
    f[F_LIGHT_PER_SAT_HLS] = q15_ratio(32'(l2), BYTE_DEN * (32'(s2) + 1));
    f[F_BLUE_NORM]         = q15_ratio(32'(b), BYTE_DEN);
    f[F_GREEN_RED_NORM]    = q15_ratio(32'(g) + 32'(r), 2 * BYTE_DEN);
    return f;
  endfunction

  always @(posedge clk) begin
    feature_set_t seen;
    feature_set_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen[F_SAT_HSV_NORM]      = out_sat_hsv_norm;
        seen[F_VAL_HSV_NORM]      = out_val_hsv_norm;
        seen[F_HUE_PER_SAT_HSV]   = out_hue_per_sat_hsv;
        seen[F_HUE_PER_VAL_HSV]   = out_hue_per_val_hsv;
        seen[F_SAT_PER_VAL_HSV]   = out_sat_per_val_hsv;
        seen[F_LIGHT_HLS_NORM]    = out_light_hls_norm;
        seen[F_SAT_HLS_NORM]      = out_sat_hls_norm;
        seen[F_HUE_PER_LIGHT_HLS] = out_hue_per_light_hls;
        seen[F_HUE_PER_SAT_HLS]   = out_hue_per_sat_hls;
        seen[F_LIGHT_PER_SAT_HLS] = out_light_per_sat_hls;
        seen[F_BLUE_NORM]         = out_blue_norm;
        seen[F_GREEN_RED_NORM]    = out_green_red_norm;
        if (expected_features.size() == 0) begin
          $error("result word with no pixel pending");
          fails++;
        end else begin
          want = expected_features.pop_front();
          for (int i = 0; i < N_FEAT; i++) begin
            if (seen[i] !== want[i]) begin
              $error("%s: expected %0d, got %0d", feature_name[i], want[i], seen[i]);
              fails++;
            end
          end
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        want = pixel_features(in_hue_hsv, in_sat_hsv, in_val_hsv, in_hue_hls,
                              in_light_hls, in_sat_hls, in_blue, in_green, in_red);
        for (int i = 0; i < N_FEAT; i++)
          if (want[i] == QUO_W'(FULL_SCALE)) clamped++;
        expected_features.push_back(want);
      end
    end
    // publish after the edge so the stimulus side sees settled counts
    fail_count    <= fails;
    pending       <= expected_features.size();
    words_checked <= checked;
    clamp_count   <= clamped;
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import pcrf_pkg::*;

  localparam int unsigned N_RANDOM   = 600;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned HUE_TOP    = 179;
  localparam int unsigned BYTE_TOP   = 255;

  typedef struct packed {
    logic [NUM_W-1:0] hue_hsv;
    logic [NUM_W-1:0] sat_hsv;
    logic [NUM_W-1:0] val_hsv;
    logic [NUM_W-1:0] hue_hls;
    logic [NUM_W-1:0] light_hls;
    logic [NUM_W-1:0] sat_hls;
    logic [NUM_W-1:0] blue;
    logic [NUM_W-1:0] green;
    logic [NUM_W-1:0] red;
  } pixel_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [NUM_W-1:0] in_hue_hsv = '0;
  logic [NUM_W-1:0] in_sat_hsv = '0;
  logic [NUM_W-1:0] in_val_hsv = '0;
  logic [NUM_W-1:0] in_hue_hls = '0;
  logic [NUM_W-1:0] in_light_hls = '0;
  logic [NUM_W-1:0] in_sat_hls = '0;
  logic [NUM_W-1:0] in_blue = '0;
  logic [NUM_W-1:0] in_green = '0;
  logic [NUM_W-1:0] in_red = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [QUO_W-1:0] out_sat_hsv_norm;
  logic [QUO_W-1:0] out_val_hsv_norm;
  logic [QUO_W-1:0] out_hue_per_sat_hsv;
  logic [QUO_W-1:0] out_hue_per_val_hsv;
  logic [QUO_W-1:0] out_sat_per_val_hsv;
  logic [QUO_W-1:0] out_light_hls_norm;
  logic [QUO_W-1:0] out_sat_hls_norm;
  logic [QUO_W-1:0] out_hue_per_light_hls;
  logic [QUO_W-1:0] out_hue_per_sat_hls;
  logic [QUO_W-1:0] out_light_per_sat_hls;
  logic [QUO_W-1:0] out_blue_norm;
  logic [QUO_W-1:0] out_green_red_norm;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_checked;
  int unsigned clamp_count;
  int unsigned pixels_sent = 0;
  int unsigned wide_hues   = 0;
  int unsigned calm_left   = 0;

  always #5 clk = ~clk;

  pixel_color_ratio_features_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_hue_hsv            (in_hue_hsv),
    .in_sat_hsv            (in_sat_hsv),
    .in_val_hsv            (in_val_hsv),
    .in_hue_hls            (in_hue_hls),
    .in_light_hls          (in_light_hls),
    .in_sat_hls            (in_sat_hls),
    .in_blue               (in_blue),
    .in_green              (in_green),
    .in_red                (in_red),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_sat_hsv_norm      (out_sat_hsv_norm),
    .out_val_hsv_norm      (out_val_hsv_norm),
    .out_hue_per_sat_hsv   (out_hue_per_sat_hsv),
    .out_hue_per_val_hsv   (out_hue_per_val_hsv),
    .out_sat_per_val_hsv   (out_sat_per_val_hsv),
    .out_light_hls_norm    (out_light_hls_norm),
    .out_sat_hls_norm      (out_sat_hls_norm),
    .out_hue_per_light_hls (out_hue_per_light_hls),
    .out_hue_per_sat_hls   (out_hue_per_sat_hls),
    .out_light_per_sat_hls (out_light_per_sat_hls),
    .out_blue_norm         (out_blue_norm),
    .out_green_red_norm    (out_green_red_norm)
  );

  pcrf_feature_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_hue_hsv            (in_hue_hsv),
    .in_sat_hsv            (in_sat_hsv),
    .in_val_hsv            (in_val_hsv),
    .in_hue_hls            (in_hue_hls),
    .in_light_hls          (in_light_hls),
    .in_sat_hls            (in_sat_hls),
    .in_blue               (in_blue),
    .in_green              (in_green),
    .in_red                (in_red),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_sat_hsv_norm      (out_sat_hsv_norm),
    .out_val_hsv_norm      (out_val_hsv_norm),
    .out_hue_per_sat_hsv   (out_hue_per_sat_hsv),
    .out_hue_per_val_hsv   (out_hue_per_val_hsv),
    .out_sat_per_val_hsv   (out_sat_per_val_hsv),
    .out_light_hls_norm    (out_light_hls_norm),
    .out_sat_hls_norm      (out_sat_hls_norm),
    .out_hue_per_light_hls (out_hue_per_light_hls),
    .out_hue_per_sat_hls   (out_hue_per_sat_hls),
    .out_light_per_sat_hls (out_light_per_sat_hls),
    .out_blue_norm         (out_blue_norm),
    .out_green_red_norm    (out_green_red_norm),
    .fail_count            (fail_count),
    .pending               (pending),
    .words_checked         (words_checked),
    .clamp_count           (clamp_count)
  );

  // Extremes and tiny values get extra weight
  function automatic logic [NUM_W-1:0] pick_byte(input int unsigned top);
    case ($urandom_range(9))
      0:       return '0;
      1:       return NUM_W'(top);
      2:       return NUM_W'($urandom_range(3));
      default: return NUM_W'($urandom_range(top));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    // hue above the nominal range now and then
    p.hue_hsv   = pick_byte(($urandom_range(9) == 0) ? BYTE_TOP : HUE_TOP);
    p.sat_hsv   = pick_byte(BYTE_TOP);
    p.val_hsv   = pick_byte(BYTE_TOP);
    p.hue_hls   = pick_byte(($urandom_range(9) == 0) ? BYTE_TOP : HUE_TOP);
    p.light_hls = pick_byte(BYTE_TOP);
    p.sat_hls   = pick_byte(BYTE_TOP);
    p.blue      = pick_byte(BYTE_TOP);
    p.green     = pick_byte(BYTE_TOP);
    p.red       = pick_byte(BYTE_TOP);
    return p;
  endfunction

  task automatic send_pixel(input pixel_t p);
    int unsigned gap;
    int unsigned roll;
    in_valid     <= 1'b1;
    in_hue_hsv   <= p.hue_hsv;
    in_sat_hsv   <= p.sat_hsv;
    in_val_hsv   <= p.val_hsv;
    in_hue_hls   <= p.hue_hls;
    in_light_hls <= p.light_hls;
    in_sat_hls   <= p.sat_hls;
    in_blue      <= p.blue;
    in_green     <= p.green;
    in_red       <= p.red;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    if (p.hue_hsv > HUE_TOP || p.hue_hls > HUE_TOP) wide_hues++;
    if (calm_left != 0) begin
      calm_left--;
      gap = 0;
    end else begin
      roll = $urandom_range(99);
      if (roll < 50) begin
        gap = 0;
      end else if (roll < 85) begin
        gap = $urandom_range(3, 1);
      end else if (roll < 95) begin
        gap = $urandom_range(10, 4);
      end else if (roll < 97) begin
        gap = 0;
        calm_left = $urandom_range(80, 20);
      end else begin
        gap = $urandom_range(60, 20);
      end
    end
    if (gap != 0) begin
      // drop valid and scramble the payload while idle
      in_valid     <= 1'b0;
      in_hue_hsv   <= NUM_W'($urandom);
      in_sat_hsv   <= NUM_W'($urandom);
      in_val_hsv   <= NUM_W'($urandom);
      in_hue_hls   <= NUM_W'($urandom);
      in_light_hls <= NUM_W'($urandom);
      in_sat_hls   <= NUM_W'($urandom);
      in_blue      <= NUM_W'($urandom);
      in_green     <= NUM_W'($urandom);
      in_red       <= NUM_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    do @(posedge clk); while (pending != 0);
  endtask

  // Result side: alternate ready runs and stalls of random length
  initial begin
    int unsigned run_len;
    int unsigned stall_len;
    forever begin
      case ($urandom_range(9))
        0:          run_len = $urandom_range(200, 50);
        1, 2, 3:    run_len = $urandom_range(20, 5);
        default:    run_len = $urandom_range(4, 1);
      endcase
      case ($urandom_range(19))
        0:          stall_len = $urandom_range(60, 20);
        1, 2, 3, 4: stall_len = $urandom_range(8, 3);
        default:    stall_len = $urandom_range(2, 1);
      endcase
      @(posedge clk);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      out_ready <= 1'b0;
      repeat (stall_len - 1) @(posedge clk);
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pixel('{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    // zero sat, val and light bytes give the largest hue ratios, just under 1.0
    send_pixel('{8'd179, 8'd0,   8'd0,   8'd179, 8'd0,   8'd0,   8'd0,   8'd255, 8'd0});
    send_pixel('{8'd180, 8'd0,   8'd255, 8'd180, 8'd255, 8'd0,   8'd255, 8'd0,   8'd255});
    send_pixel('{8'd1,   8'd255, 8'd255, 8'd1,   8'd255, 8'd255, 8'd1,   8'd1,   8'd0});
    send_pixel('{8'd90,  8'd255, 8'd0,   8'd90,  8'd0,   8'd255, 8'd128, 8'd128, 8'd127});
    send_pixel('{8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd254, 8'd0,   8'd1});
    send_pixel('{8'h55,  8'h55,  8'h55,  8'h55,  8'h55,  8'h55,  8'h55,  8'h55,  8'h55});
    send_pixel('{8'hAA,  8'hAA,  8'hAA,  8'hAA,  8'hAA,  8'hAA,  8'hAA,  8'hAA,  8'hAA});
    send_pixel('{8'd255, 8'd1,   8'd1,   8'd255, 8'd1,   8'd1,   8'd2,   8'd3,   8'd4});
    send_pixel('{8'd128, 8'd127, 8'd127, 8'd128, 8'd127, 8'd127, 8'd127, 8'd128, 8'd128});
    send_pixel('{8'd0,   8'd1,   8'd0,   8'd0,   8'd1,   8'd0,   8'd254, 8'd1,   8'd1});
    send_pixel('{8'd179, 8'd1,   8'd3,   8'd179, 8'd3,   8'd1,   8'd64,  8'd200, 8'd55});
    send_pixel('{8'd179, 8'd255, 8'd255, 8'd179, 8'd255, 8'd255, 8'd0,   8'd0,   8'd255});
    // hold off until the pipeline is empty
    in_valid <= 1'b0;
    drain();

    for (n = 0; n < N_RANDOM; n++) begin
      if (n % 150 == 149) begin
        in_valid <= 1'b0;
        drain();
      end
      send_pixel(random_pixel());
    end
    in_valid <= 1'b0;
    drain();
    repeat (24) @(posedge clk);

    $display("Run covered %0d pixels (%0d with hue bytes past 179), %0d result words compared",
             pixels_sent, wide_hues, words_checked);
    $display("%0d features clamped at 1.0, %0d mismatches", clamp_count, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
